@@ sv/arpc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types, codes and sizes for the ARP cache with aging.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int IP_W    = 32;
  localparam int MAC_W   = 48;
  localparam int TIME_W  = 32;
  localparam int CNT_W   = 5;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;
  localparam logic [1:0] CMD_SWEEP  = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic [TIME_W-1:0] MAX_AGE_RESET = 32'd1000;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [IP_W-1:0]  ip_addr;
    logic [MAC_W-1:0] hw_addr;
  } req_t;

  typedef struct packed {
    logic             hit;
    logic [MAC_W-1:0] found_mac;
    logic [1:0]       status;
    logic [CNT_W-1:0] removed_count;
  } rsp_t;

  // token handed from cell to cell
  typedef struct packed {
    logic             active;
    logic [1:0]       cmd;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] new_mac;
    logic             hit;
    logic [MAC_W-1:0] found_mac;
    logic             dup;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic [CNT_W-1:0] count;
  } link_t;

  // insert commit broadcast to all cells
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [IP_W-1:0]   ip;
    logic [MAC_W-1:0]  mac;
    logic [TIME_W-1:0] stamp;
  } wr_t;

endpackage
`default_nettype wire

@@ sv/arpc_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// arpc_cell
// One cache slot; updates the passing request token and hands it on.
// ----------------------------------------------------------------------------
module arpc_cell
  import arpc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [IDX_W-1:0]  idx,
  input  wire logic [TIME_W-1:0] now,
  input  wire logic [TIME_W-1:0] max_age,
  input  wire wr_t               wr,
  input  wire link_t             link_in,
  output link_t                  link_out
);

  logic              valid;
  logic [IP_W-1:0]   ip;
  logic [MAC_W-1:0]  mac;
  logic [TIME_W-1:0] stamp;

  logic              key_match;
  logic [TIME_W-1:0] age;
  logic              expired;
  logic              sweep_clr;
  link_t             link_next;

  assign key_match = valid && (ip == link_in.ip);
  assign age       = now - stamp;
  assign expired   = valid && (age >= max_age);
  assign sweep_clr = link_in.active && (link_in.cmd == CMD_SWEEP) && expired;

  always_comb begin
    link_next = link_in;
    unique case (link_in.cmd)
      CMD_LOOKUP: begin
        if (key_match && !link_in.hit) begin
          link_next.hit       = 1'b1;
          link_next.found_mac = mac;
        end
      end
      CMD_INSERT: begin
        if (key_match) begin
          link_next.dup = 1'b1;
        end
        if (!valid && !link_in.free_found) begin
          link_next.free_found = 1'b1;
          link_next.free_idx   = idx;
        end
      end
      CMD_SWEEP: begin
        if (expired && (link_in.count != CNT_MAX)) begin
          link_next.count = link_in.count + CNT_W'(1);
        end
      end
      CMD_TICK: begin
        link_next = link_in;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= 1'b0;
      link_out <= '0;
    end else begin
      if (wr.en && (wr.idx == idx)) begin
        valid <= 1'b1;
      end else if (sweep_clr) begin
        valid <= 1'b0;
      end
      link_out <= link_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx == idx)) begin
      ip    <= wr.ip;
      mac   <= wr.mac;
      stamp <= wr.stamp;
    end
  end

endmodule
`default_nettype wire

@@ sv/arp_cache_with_aging_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// arp_cache_with_aging_unit
// ARP cache mapping IPv4 addresses to MAC addresses, with tick-based aging.
// ----------------------------------------------------------------------------
// The cache is a row of ENTRIES slot cells. A lookup, insert or sweep request
// enters a head register and travels down the row one cell per cycle; each
// cell checks its own slot against the token (match, first free slot, expiry)
// and hands the token on. When the token leaves the last cell the response is
// formed and, for an insert of a new address with a free slot, the pair and
// the current time are written into the lowest free slot. The response to a
// lookup, insert or sweep is registered from the token leaving the row; one
// request is in the row at a time. A tick is answered on the cycle after it
// is taken. Every request gives exactly one response. max_age is written
// through cfg_wr_en / cfg_wr_data and must only change while no request is
// outstanding. Slot contents are only ever read behind their valid bit, so
// there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module arp_cache_with_aging_unit
  import arpc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // request channel
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire req_t              req,
  // response channel
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output rsp_t                   rsp,
  // max_age register
  input  wire logic              cfg_wr_en,
  input  wire logic [TIME_W-1:0] cfg_wr_data
);

  logic              busy;
  logic [TIME_W-1:0] now;
  logic [TIME_W-1:0] max_age;
  link_t             head;
  link_t             link [0:ENTRIES];
  link_t             tail;
  wr_t               wr;
  rsp_t              rsp_next;

  logic req_fire;
  logic rsp_fire;
  logic tick_fire;
  logic chain_fire;

  // a new request is held off while one is in the row or a response waits
  assign req_stall  = busy || (rsp_valid && rsp_stall);
  assign req_fire   = req_valid && !req_stall;
  assign rsp_fire   = rsp_valid && !rsp_stall;
  assign tick_fire  = req_fire && (req.cmd == CMD_TICK);
  assign chain_fire = req_fire && (req.cmd != CMD_TICK);

  // head of the row: token starts clean
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
    end else begin
      head.active <= chain_fire;
      if (chain_fire) begin
        head.cmd        <= req.cmd;
        head.ip         <= req.ip_addr;
        head.new_mac    <= req.hw_addr;
        head.hit        <= 1'b0;
        head.found_mac  <= '0;
        head.dup        <= 1'b0;
        head.free_found <= 1'b0;
        head.free_idx   <= '0;
        head.count      <= '0;
      end
    end
  end

  assign link[0] = head;

  // row of slot cells
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    arpc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (IDX_W'(i)),
      .now      (now),
      .max_age  (max_age),
      .wr       (wr),
      .link_in  (link[i]),
      .link_out (link[i+1])
    );
  end

  assign tail = link[ENTRIES];

  // insert commit: new address and a free slot found along the row
  always_comb begin
    wr.en    = tail.active && (tail.cmd == CMD_INSERT) && !tail.dup && tail.free_found;
    wr.idx   = tail.free_idx;
    wr.ip    = tail.ip;
    wr.mac   = tail.new_mac;
    wr.stamp = now;
  end

  // response from the token leaving the row
  always_comb begin
    rsp_next               = '0;
    rsp_next.hit           = (tail.cmd == CMD_LOOKUP) && tail.hit;
    rsp_next.found_mac     = rsp_next.hit ? tail.found_mac : '0;
    rsp_next.removed_count = (tail.cmd == CMD_SWEEP) ? tail.count : '0;
    if (tail.cmd == CMD_INSERT) begin
      priority if (tail.dup) begin
        rsp_next.status = ST_PRESENT;
      end else if (!tail.free_found) begin
        rsp_next.status = ST_FULL;
      end else begin
        rsp_next.status = ST_DONE;
      end
    end
  end

  // control, time counter and register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      rsp_valid <= 1'b0;
      now       <= '0;
      max_age   <= MAX_AGE_RESET;
    end else begin
      if (cfg_wr_en) begin
        max_age <= cfg_wr_data;
      end
      if (tick_fire) begin
        now <= now + TIME_W'(1);
      end
      if (chain_fire) begin
        busy <= 1'b1;
      end else if (tail.active) begin
        busy <= 1'b0;
      end
      if (tick_fire || tail.active) begin
        rsp_valid <= 1'b1;
      end else if (rsp_fire) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (tick_fire) begin
      rsp <= '0;
    end else if (tail.active) begin
      rsp <= rsp_next;
    end
  end

endmodule
`default_nettype wire

@@ sim/tb_arp_cache_with_aging_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_arp_cache_with_aging_unit
// Self-checking bench for the ARP cache: lookups, inserts, ticks and sweeps
// are predicted by a shadow table and each response is compared in order.
// ----------------------------------------------------------------------------
module tb_arp_cache_with_aging_unit;
  import arpc_pkg::*;

  localparam int CYCLE_LIMIT = 500_000;
  // cell row depth plus head and output registers
  localparam int ROW_LATENCY = ENTRIES + 2;
  // more addresses than slots so the table fills and drops
  localparam int POOL_SIZE   = 24;

  logic              clk         = 1'b0;
  logic              rst         = 1'b1;
  logic              req_valid   = 1'b0;
  logic              req_stall;
  req_t              req         = '0;
  logic              rsp_valid;
  logic              rsp_stall   = 1'b0;
  rsp_t              rsp;
  logic              cfg_wr_en   = 1'b0;
  logic [TIME_W-1:0] cfg_wr_data = '0;

  arp_cache_with_aging_unit dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // shadow copy of the cache contents and the aging setup
  logic              slot_valid [ENTRIES];
  logic [IP_W-1:0]   slot_ip    [ENTRIES];
  logic [MAC_W-1:0]  slot_mac   [ENTRIES];
  logic [TIME_W-1:0] slot_stamp [ENTRIES];
  logic [TIME_W-1:0] model_now;
  logic [TIME_W-1:0] model_max_age;

  // responses owed by the cache, oldest first
  rsp_t cache_answers_due [$];

  // idle control shared by the sender and the response stall process
  int gap_pct    = 0;
  int stall_pct  = 0;
  int stall_left = 0;

  int unsigned cycle_count = 0;
  int requests_taken = 0;
  int mismatches     = 0;
  int hits_seen      = 0;
  int stored_seen    = 0;
  int dup_seen       = 0;
  int full_seen      = 0;
  int sweeps_seen    = 0;
  int evicted_seen   = 0;
  int age_settings   = 0;

  logic [IP_W-1:0] ip_pool [POOL_SIZE];

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // shadow table: works out the response of one request and updates state
  // ---------------------------------------------------------------------------
  function automatic rsp_t predict_cache_answer(input req_t r);
    rsp_t              ans;
    int                match_slot;
    int                free_slot;
    logic [TIME_W-1:0] age;
    ans        = '0;
    match_slot = -1;
    free_slot  = -1;
    // first valid match and lowest free slot
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_valid[i] && slot_ip[i] == r.ip_addr && match_slot < 0) match_slot = i;
      if (!slot_valid[i] && free_slot < 0) free_slot = i;
    end
    case (r.cmd)
      CMD_LOOKUP: begin
        // a miss leaves hit and mac at zero
        if (match_slot >= 0) begin
          ans.hit       = 1'b1;
          ans.found_mac = slot_mac[match_slot];
          hits_seen++;
        end
      end
      CMD_INSERT: begin
        // a known address keeps its old mac and stamp
        if (match_slot >= 0) begin
          ans.status = ST_PRESENT;
          dup_seen++;
        end else if (free_slot < 0) begin
          ans.status = ST_FULL;
          full_seen++;
        end else begin
          slot_valid[free_slot] = 1'b1;
          slot_ip[free_slot]    = r.ip_addr;
          slot_mac[free_slot]   = r.hw_addr;
          slot_stamp[free_slot] = model_now;
          stored_seen++;
        end
      end
      CMD_TICK: begin
        model_now = model_now + 1'b1;
      end
      CMD_SWEEP: begin
        // age taken mod 2^32, so a zero max_age clears every entry
        for (int i = 0; i < ENTRIES; i++) begin
          age = model_now - slot_stamp[i];
          if (slot_valid[i] && age >= model_max_age) begin
            slot_valid[i] = 1'b0;
            if (ans.removed_count != CNT_MAX) ans.removed_count++;
          end
        end
        sweeps_seen++;
        evicted_seen += ans.removed_count;
      end
    endcase
    return ans;
  endfunction

  // ---------------------------------------------------------------------------
  // one process: predict on each accepted request, check each response
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : answer_check
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) slot_valid[i] = 1'b0;
      model_now     = '0;
      model_max_age = MAX_AGE_RESET;
    end else begin
      if (req_valid && req_stall === 1'b0) begin
        cache_answers_due.push_back(predict_cache_answer(req));
        requests_taken++;
      end
      if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
        if (cache_answers_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"unexpected response at cycle %0d: ",
                      "hit %0b mac %h status %0d removed %0d"},
                     cycle_count, rsp.hit, rsp.found_mac, rsp.status, rsp.removed_count);
        end else begin
          want = cache_answers_due.pop_front();
          if (rsp.hit !== want.hit || rsp.found_mac !== want.found_mac ||
              rsp.status !== want.status || rsp.removed_count !== want.removed_count) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch at cycle %0d (exp/got): hit %0b/%0b mac %h/%h ",
                        "status %0d/%0d removed %0d/%0d"},
                       cycle_count, want.hit, rsp.hit, want.found_mac, rsp.found_mac,
                       want.status, rsp.status, want.removed_count, rsp.removed_count);
          end
        end
      end
    end
  end

  // response side back-pressure in random bursts
  initial begin
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        rsp_stall <= 1'b1;
        stall_left--;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        rsp_stall  <= 1'b1;
        stall_left = $urandom_range(1, 14) - 1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses still owed",
               cycle_count, cache_answers_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // shared driver tasks
  // ---------------------------------------------------------------------------

  // offer one request, optionally after an idle burst; valid stays high on
  // return so back-to-back requests need no drop
  task automatic send_request(input logic [1:0] cmd, input logic [IP_W-1:0] ip,
                              input logic [MAC_W-1:0] mac);
    req_t r;
    int   gap;
    r.cmd      = cmd;
    r.ip_addr  = ip;
    r.hw_addr  = mac;
    gap        = 0;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 14);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall !== 1'b0);
  endtask

  // drop valid and wait until every owed response is back
  task automatic wait_until_idle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (cache_answers_due.size() != 0) @(posedge clk);
    repeat (ROW_LATENCY) @(posedge clk);
  endtask

  // max_age may only move while the row is empty
  task automatic write_max_age(input logic [TIME_W-1:0] value);
    wait_until_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en     <= 1'b0;
    model_max_age = value;
    age_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // miss on empty table, extreme keys and macs, duplicate insert keeps old mac
  task automatic test_lookup_and_insert();
    send_request(CMD_LOOKUP, '0, '0);
    send_request(CMD_INSERT, '0, '0);
    send_request(CMD_INSERT, '1, '1);
    send_request(CMD_LOOKUP, '1, '0);
    send_request(CMD_INSERT, '0, 48'hA5A5_5A5A_C3C3);
    send_request(CMD_LOOKUP, '0, '1);
  endtask

  // fill the remaining slots, then a new key is dropped, a known one ignored
  task automatic test_table_full();
    logic [MAC_W-1:0] mac;
    for (int i = 0; i < ENTRIES - 2; i++) begin
      mac[47:32] = $urandom;
      mac[31:0]  = $urandom;
      send_request(CMD_INSERT, 32'h0A00_0001 + i, mac);
    end
    send_request(CMD_INSERT, 32'hC0A8_FFFE, 48'h0000_1111_2222);
    send_request(CMD_INSERT, '1, 48'h0000_3333_4444);
  endtask

  // smallest age clears the full table, zero age clears fresh entries,
  // largest age keeps everything
  task automatic test_aging_extremes();
    write_max_age(32'd1);
    send_request(CMD_TICK, '0, '0);
    send_request(CMD_SWEEP, '0, '0);
    write_max_age('0);
    send_request(CMD_INSERT, 32'hC0A8_0001, 48'h0200_0000_0001);
    send_request(CMD_SWEEP, '0, '0);
    write_max_age('1);
    send_request(CMD_INSERT, 32'hC0A8_0002, 48'h0200_0000_0002);
    send_request(CMD_TICK, '0, '0);
    send_request(CMD_SWEEP, '0, '0);
  endtask

  // mixed traffic over a small address pool so hits, duplicates, full-table
  // drops and evictions all recur
  task automatic run_random_traffic(input int count, input logic [TIME_W-1:0] age,
                                    input bit pause_midway, input bit calm);
    int               pick;
    logic [1:0]       cmd;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
    if (calm) begin
      gap_pct   = 0;
      stall_pct = 0;
    end
    write_max_age(age);
    foreach (ip_pool[k]) ip_pool[k] = $urandom;
    for (int n = 0; n < count; n++) begin
      // reshuffle idle levels every 50 requests, some stretches fully busy
      if (n % 50 == 0 && !calm) begin
        if ($urandom_range(0, 3) == 0) begin
          gap_pct   = 0;
          stall_pct = 0;
        end else begin
          gap_pct   = $urandom_range(5, 35);
          stall_pct = $urandom_range(5, 35);
        end
      end
      // hold off until the cache has answered everything
      if (pause_midway && n == count / 2) wait_until_idle();
      pick       = $urandom_range(0, 99);
      ip         = ($urandom_range(0, 4) == 0) ? $urandom
                                               : ip_pool[$urandom_range(0, POOL_SIZE - 1)];
      mac[47:32] = $urandom;
      mac[31:0]  = $urandom;
      if (pick < 35)      cmd = CMD_LOOKUP;
      else if (pick < 65) cmd = CMD_INSERT;
      else if (pick < 90) cmd = CMD_TICK;
      else                cmd = CMD_SWEEP;
      send_request(cmd, ip, mac);
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    gap_pct   = 20;
    stall_pct = 20;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_lookup_and_insert();
    test_table_full();
    test_aging_extremes();
    run_random_traffic(210, 32'($urandom_range(2, 30)), 1'b0, 1'b0);
    run_random_traffic(210, MAX_AGE_RESET, 1'b0, 1'b0);
    run_random_traffic(210, $urandom, 1'b1, 1'b0);
    run_random_traffic(210, 32'($urandom_range(3, 12)), 1'b0, 1'b0);
    // closing stretch without any idling
    run_random_traffic(210, 32'd8, 1'b0, 1'b1);
    wait_until_idle();

    $display({"run covered %0d requests: %0d lookup hits, %0d new entries, ",
              "%0d duplicate and %0d full-table inserts"},
             requests_taken, hits_seen, stored_seen, dup_seen, full_seen);
    $display("%0d sweeps evicted %0d entries across %0d max_age settings; %0d mismatches",
             sweeps_seen, evicted_seen, age_settings, mismatches);
    if (mismatches == 0 && cache_answers_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
